>>> src/priority_ceiling_task_scheduler_defines.svh
// Assertion macros used by the scheduler controller.
`ifndef PRIORITY_CEILING_TASK_SCHEDULER_DEFINES_SVH
`define PRIORITY_CEILING_TASK_SCHEDULER_DEFINES_SVH

// Same-cycle implication, checked on clk outside reset.
`define PCTS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on clk outside reset.
`define PCTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/pcts_pkg.sv
// Shared types, codes and constants of the priority ceiling task scheduler.
package pcts_pkg;

  localparam int MAX_TASKS        = 8;
  localparam int MAX_RESOURCES    = 8;
  localparam int MAX_INSTRUCTIONS = 16;

  localparam logic [1:0] OP_HDR   = 2'd0;
  localparam logic [1:0] OP_INSTR = 2'd1;
  localparam logic [1:0] OP_RUN   = 2'd2;

  localparam logic [1:0] K_COMPUTE = 2'd0;
  localparam logic [1:0] K_LOCK    = 2'd1;
  localparam logic [1:0] K_UNLOCK  = 2'd2;

  localparam logic REG_TASK_COUNT     = 1'b0;
  localparam logic REG_RESOURCE_COUNT = 1'b1;

  localparam logic [31:0] TIME_MAX = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [1:0]  operation;
    logic [2:0]  task_index;
    logic [15:0] start_time;
    logic [7:0]  base_priority;
    logic [4:0]  instr_count;
    logic [3:0]  slot;
    logic [1:0]  kind;
    logic [15:0] value;
  } in_t;

  typedef struct packed {
    logic [2:0]  done_task;
    logic [31:0] done_time;
    logic        last;
  } out_t;

  typedef struct packed {
    logic load_hdr;
    logic load_ins;
    logic run_init;
    logic fetch_cap;
    logic len_check;
    logic idx_inc;
    logic idx_clear;
    logic pick_start;
    logic pick_eval;
    logic pass_restart;
    logic jump_clock;
    logic deadlock;
    logic ticks_prep;
    logic compute_apply;
    logic step_instr;
    logic clear_ceil;
    logic emit_load;
  } cmd_t;

  typedef struct packed {
    logic idx_last;
    logic all_done;
    logic changed;
    logic have_best;
    logic found;
    logic is_compute;
    logic step_ends;
    logic out_free;
  } stat_t;

endpackage

>>> src/pcts_datapath.sv
// Scheduler datapath: task tables, program memory, resource state, time and result register.
module pcts_datapath (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_we,
  input  logic           cfg_index,
  input  logic [3:0]     cfg_data,
  input  pcts_pkg::in_t  in_data,
  input  pcts_pkg::cmd_t cmd,
  input  logic           out_stall,
  output pcts_pkg::stat_t stat,
  output pcts_pkg::out_t out_data,
  output logic           out_valid
);

  logic [3:0]  task_count;
  logic [3:0]  resource_count;
  logic [2:0]  nt_m1;
  logic [3:0]  nr;

  logic [15:0] task_start     [pcts_pkg::MAX_TASKS];
  logic [7:0]  task_base_prio [pcts_pkg::MAX_TASKS];
  logic [4:0]  task_length    [pcts_pkg::MAX_TASKS];
  logic [4:0]  task_pointer   [pcts_pkg::MAX_TASKS];
  logic [1:0]  cur_kind       [pcts_pkg::MAX_TASKS];
  logic [15:0] cur_val        [pcts_pkg::MAX_TASKS];
  logic [7:0]  current_prio   [pcts_pkg::MAX_TASKS];
  logic [31:0] finish_time    [pcts_pkg::MAX_TASKS];
  logic        done_flag      [pcts_pkg::MAX_TASKS];
  logic [7:0]  resource_ceiling [pcts_pkg::MAX_RESOURCES];
  logic [3:0]  resource_holder  [pcts_pkg::MAX_RESOURCES];

  logic [17:0] prog_mem [pcts_pkg::MAX_TASKS * pcts_pkg::MAX_INSTRUCTIONS];
  logic [17:0] rd_data;
  logic [6:0]  rd_addr;
  logic        mem_we;
  logic [6:0]  mem_waddr;
  logic [17:0] mem_wdata;

  logic [31:0] clock_now;
  logic [3:0]  finished_count;
  logic [2:0]  idx;
  logic        changed;
  logic        have_best;
  logic [2:0]  best;
  logic [7:0]  bestp;
  logic        found;
  logic [15:0] when;
  logic [15:0] ticks;

  // evaluation of the task at idx
  logic [7:0]  p;
  logic        elig;
  logic        lockv;
  logic [7:0]  raise;
  logic [7:0]  up;
  logic        blocked;

  // execution of the chosen task
  logic [1:0]  ek;
  logic [15:0] ev;
  logic [15:0] ev_left;
  logic        rvalid;
  logic [31:0] gap;
  logic [32:0] sum;

  function automatic logic [4:0] elen(input logic [4:0] len);
    elen = (len > 5'(pcts_pkg::MAX_INSTRUCTIONS)) ? 5'(pcts_pkg::MAX_INSTRUCTIONS) : len;
  endfunction

  assign nt_m1 = (task_count == 4'd0) ? 3'd0 :
                 (task_count >= 4'(pcts_pkg::MAX_TASKS)) ? 3'(pcts_pkg::MAX_TASKS - 1) :
                 3'(task_count - 4'd1);
  assign nr = (resource_count == 4'd0) ? 4'd1 :
              (resource_count > 4'(pcts_pkg::MAX_RESOURCES)) ? 4'(pcts_pkg::MAX_RESOURCES) :
              resource_count;

  assign p     = current_prio[idx];
  assign elig  = !done_flag[idx] && (clock_now >= {16'd0, task_start[idx]}) &&
                 (task_pointer[idx] < elen(task_length[idx]));
  assign lockv = (cur_kind[idx] == pcts_pkg::K_LOCK) && (cur_val[idx] != 16'd0) &&
                 (cur_val[idx] <= {12'd0, nr});

  always_comb begin
    for (int j = 0; j < pcts_pkg::MAX_RESOURCES; j++) begin
      raise[j] = elig && lockv && (resource_holder[j] != 4'd0) &&
                 (((cur_val[idx][3:0] - 4'd1) == 4'(j)) ||
                  ((4'(j) < nr) && (resource_holder[j] != ({1'b0, idx} + 4'd1)) &&
                   (resource_ceiling[j] >= p)));
    end
    for (int x = 0; x < pcts_pkg::MAX_TASKS; x++) begin
      up[x] = 1'b0;
      for (int j = 0; j < pcts_pkg::MAX_RESOURCES; j++) begin
        if (raise[j] && (resource_holder[j] == 4'(x + 1)) && (current_prio[x] < p)) begin
          up[x] = 1'b1;
        end
      end
    end
  end

  assign blocked = |raise;

  assign ek      = cur_kind[best];
  assign ev      = cur_val[best];
  assign ev_left = ev - ticks;
  assign rvalid  = (ev != 16'd0) && (ev <= {12'd0, nr});
  assign gap     = {16'd0, when} - clock_now;
  assign sum     = {1'b0, clock_now} + {17'd0, ticks};

  assign stat.idx_last   = (idx == nt_m1);
  assign stat.all_done   = (finished_count >= ({1'b0, nt_m1} + 4'd1));
  assign stat.changed    = changed;
  assign stat.have_best  = have_best;
  assign stat.found      = found;
  assign stat.is_compute = (ek == pcts_pkg::K_COMPUTE) && (ev != 16'd0);
  assign stat.step_ends  = ((task_pointer[best] + 5'd1) >= elen(task_length[best]));
  assign stat.out_free   = !out_valid || !out_stall;

  // program memory: one write port, one registered read port
  assign rd_addr   = {idx, task_pointer[idx][3:0]};
  assign mem_we    = cmd.load_ins || cmd.compute_apply;
  assign mem_waddr = cmd.load_ins ? {in_data.task_index, in_data.slot}
                                  : {best, task_pointer[best][3:0]};
  assign mem_wdata = cmd.load_ins ? {in_data.kind, in_data.value} : {ek, ev_left};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      prog_mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= prog_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      task_count     <= 4'd1;
      resource_count <= 4'd1;
      clock_now      <= '0;
      finished_count <= '0;
      idx            <= '0;
      changed        <= 1'b0;
      have_best      <= 1'b0;
      best           <= '0;
      bestp          <= '0;
      found          <= 1'b0;
      when           <= '0;
      ticks          <= '0;
      out_valid      <= 1'b0;
      for (int x = 0; x < pcts_pkg::MAX_TASKS; x++) begin
        task_pointer[x] <= '0;
        current_prio[x] <= '0;
        finish_time[x]  <= '0;
        done_flag[x]    <= 1'b0;
      end
      for (int j = 0; j < pcts_pkg::MAX_RESOURCES; j++) begin
        resource_ceiling[j] <= '0;
        resource_holder[j]  <= '0;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          pcts_pkg::REG_TASK_COUNT:     task_count     <= cfg_data;
          pcts_pkg::REG_RESOURCE_COUNT: resource_count <= cfg_data;
        endcase
      end

      if (cmd.load_hdr) begin
        task_start[in_data.task_index]     <= in_data.start_time;
        task_base_prio[in_data.task_index] <= in_data.base_priority;
        task_length[in_data.task_index]    <= in_data.instr_count;
      end

      // ceiling follows every lock on resource 1 to MAX_RESOURCES loaded into a program
      if (cmd.load_ins && (in_data.kind == pcts_pkg::K_LOCK) && (in_data.value != 16'd0) &&
          (in_data.value <= 16'(pcts_pkg::MAX_RESOURCES)) &&
          (resource_ceiling[3'(in_data.value[3:0] - 4'd1)] <
           task_base_prio[in_data.task_index])) begin
        resource_ceiling[3'(in_data.value[3:0] - 4'd1)] <= task_base_prio[in_data.task_index];
      end

      if (cmd.run_init) begin
        clock_now      <= '0;
        finished_count <= '0;
        for (int x = 0; x < pcts_pkg::MAX_TASKS; x++) begin
          task_pointer[x] <= '0;
          finish_time[x]  <= '0;
          done_flag[x]    <= 1'b0;
        end
        for (int j = 0; j < pcts_pkg::MAX_RESOURCES; j++) begin
          resource_holder[j] <= '0;
        end
      end

      if (cmd.fetch_cap) begin
        cur_kind[idx] <= rd_data[17:16];
        cur_val[idx]  <= rd_data[15:0];
        if (cmd.len_check && (elen(task_length[idx]) == 5'd0)) begin
          done_flag[idx] <= 1'b1;
          finished_count <= finished_count + 4'd1;
        end
      end

      if (cmd.pick_start) begin
        for (int x = 0; x < pcts_pkg::MAX_TASKS; x++) begin
          current_prio[x] <= task_base_prio[x];
        end
      end

      if (cmd.pick_start || cmd.pass_restart) begin
        changed   <= 1'b0;
        have_best <= 1'b0;
        bestp     <= '0;
        found     <= 1'b0;
      end

      if (cmd.pick_eval) begin
        for (int x = 0; x < pcts_pkg::MAX_TASKS; x++) begin
          if (up[x]) begin
            current_prio[x] <= p;
          end
        end
        if (|up) begin
          changed <= 1'b1;
        end
        if (elig && !blocked && (p > bestp)) begin
          bestp     <= p;
          best      <= idx;
          have_best <= 1'b1;
        end
        if (!done_flag[idx] && ({16'd0, task_start[idx]} > clock_now) &&
            (!found || (task_start[idx] < when))) begin
          when  <= task_start[idx];
          found <= 1'b1;
        end
      end

      if (cmd.jump_clock) begin
        clock_now <= {16'd0, when};
      end

      if (cmd.deadlock) begin
        for (int x = 0; x < pcts_pkg::MAX_TASKS; x++) begin
          if ((3'(x) <= nt_m1) && !done_flag[x]) begin
            finish_time[x] <= pcts_pkg::TIME_MAX;
            done_flag[x]   <= 1'b1;
          end
        end
      end

      // compute runs until done or until the next task start, whichever is first
      if (cmd.ticks_prep) begin
        ticks <= (found && (gap < {16'd0, ev})) ? gap[15:0] : ev;
      end

      if (cmd.compute_apply) begin
        cur_val[best] <= ev_left;
        clock_now     <= sum[32] ? pcts_pkg::TIME_MAX : sum[31:0];
      end

      if (cmd.step_instr) begin
        if (rvalid && (ek == pcts_pkg::K_LOCK)) begin
          resource_holder[3'(ev[3:0] - 4'd1)] <= {1'b0, best} + 4'd1;
        end else if (rvalid && (ek == pcts_pkg::K_UNLOCK)) begin
          resource_holder[3'(ev[3:0] - 4'd1)] <= 4'd0;
        end
        task_pointer[best] <= task_pointer[best] + 5'd1;
        if (stat.step_ends) begin
          finish_time[best] <= clock_now;
          done_flag[best]   <= 1'b1;
          finished_count    <= finished_count + 4'd1;
        end
      end

      if (cmd.clear_ceil) begin
        for (int j = 0; j < pcts_pkg::MAX_RESOURCES; j++) begin
          resource_ceiling[j] <= '0;
        end
      end

      if (cmd.idx_clear) begin
        idx <= '0;
      end else if (cmd.idx_inc) begin
        idx <= idx + 3'd1;
      end else if (cmd.step_instr) begin
        idx <= best;
      end

      if (cmd.emit_load) begin
        out_data.done_task <= idx;
        out_data.done_time <= finish_time[idx];
        out_data.last      <= stat.idx_last;
        out_valid          <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

>>> src/pcts_controller.sv
// Scheduler controller: sequences loads, the run loop and the result beats.
`include "priority_ceiling_task_scheduler_defines.svh"

module pcts_controller (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic [1:0]      op,
  input  pcts_pkg::stat_t stat,
  output logic            in_stall,
  output pcts_pkg::cmd_t  cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_INIT  = 4'd1;
  localparam logic [3:0] S_FREQ  = 4'd2;
  localparam logic [3:0] S_FCAP  = 4'd3;
  localparam logic [3:0] S_CHECK = 4'd4;
  localparam logic [3:0] S_PICK  = 4'd5;
  localparam logic [3:0] S_PEND  = 4'd6;
  localparam logic [3:0] S_COMP  = 4'd7;
  localparam logic [3:0] S_FIN   = 4'd8;
  localparam logic [3:0] S_EMIT  = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       init_phase;
  logic       init_phase_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next      = state;
    init_phase_next = init_phase;
    cmd             = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_hdr = (op == pcts_pkg::OP_HDR);
          cmd.load_ins = (op == pcts_pkg::OP_INSTR);
          if (op == pcts_pkg::OP_RUN) begin
            state_next = S_INIT;
          end
        end
      end
      S_INIT: begin
        cmd.run_init    = 1'b1;
        cmd.idx_clear   = 1'b1;
        init_phase_next = 1'b1;
        state_next      = S_FREQ;
      end
      S_FREQ: begin
        state_next = S_FCAP;
      end
      S_FCAP: begin
        cmd.fetch_cap = 1'b1;
        cmd.len_check = init_phase;
        if (init_phase && !stat.idx_last) begin
          cmd.idx_inc = 1'b1;
          state_next  = S_FREQ;
        end else begin
          init_phase_next = 1'b0;
          state_next      = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.all_done) begin
          state_next = S_FIN;
        end else begin
          cmd.pick_start = 1'b1;
          cmd.idx_clear  = 1'b1;
          state_next     = S_PICK;
        end
      end
      S_PICK: begin
        cmd.pick_eval = 1'b1;
        if (stat.idx_last) begin
          state_next = S_PEND;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_PEND: begin
        if (stat.changed) begin
          cmd.pass_restart = 1'b1;
          cmd.idx_clear    = 1'b1;
          state_next       = S_PICK;
        end else if (!stat.have_best) begin
          if (stat.found) begin
            cmd.jump_clock = 1'b1;
            state_next     = S_CHECK;
          end else begin
            cmd.deadlock = 1'b1;
            state_next   = S_FIN;
          end
        end else if (stat.is_compute) begin
          cmd.ticks_prep = 1'b1;
          state_next     = S_COMP;
        end else begin
          cmd.step_instr = 1'b1;
          state_next     = stat.step_ends ? S_CHECK : S_FREQ;
        end
      end
      S_COMP: begin
        cmd.compute_apply = 1'b1;
        state_next        = S_CHECK;
      end
      S_FIN: begin
        cmd.clear_ceil = 1'b1;
        cmd.idx_clear  = 1'b1;
        state_next     = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit_load = 1'b1;
          if (stat.idx_last) begin
            state_next = S_IDLE;
          end else begin
            cmd.idx_inc = 1'b1;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      init_phase <= 1'b0;
    end else begin
      state      <= state_next;
      init_phase <= init_phase_next;
    end
  end

  `PCTS_ASSERT_NEXT(a_run_enters_init, (state == S_IDLE) && in_valid && (op == pcts_pkg::OP_RUN), state == S_INIT, "run beat did not start a run")
  `PCTS_ASSERT_NOW(a_emit_has_room, cmd.emit_load, stat.out_free, "result loaded over a waiting beat")
  `PCTS_ASSERT_NOW(a_exec_has_task, cmd.ticks_prep || cmd.step_instr, stat.have_best, "step executed with no chosen task")

endmodule

>>> src/priority_ceiling_task_scheduler.sv
// Top level of the priority ceiling task scheduler.
// A header beat or an instruction beat is taken while the block is idle, and
// the block is ready for the next beat right away. A run beat holds the
// input stalled while the run executes: first the first instruction of each
// task is fetched, then each scheduling step makes one inheritance pass over
// every task in use (repeated until no priority rises), executes the step
// and, when the task moves on to a next instruction, fetches it from the
// program memory. Compute steps jump the time forward by their whole
// remaining count or up to the next task start, so run time follows the
// number of instructions, not the number of ticks. The run ends with one
// result beat per task in task order, last set on the final one; the output
// register lets the next beat be accepted while the last result still waits.
module priority_ceiling_task_scheduler (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  pcts_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output pcts_pkg::out_t out_data,
  input  logic           cfg_we,
  input  logic           cfg_index,
  input  logic [3:0]     cfg_data
);

  pcts_pkg::cmd_t  cmd;
  pcts_pkg::stat_t stat;

  // sequencing of loads, inheritance passes, steps and result beats
  pcts_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .op       (in_data.operation),
    .stat     (stat),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  // task tables, program memory, resource holders and ceilings, time
  pcts_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .out_stall (out_stall),
    .stat      (stat),
    .out_data  (out_data),
    .out_valid (out_valid)
  );

endmodule

>>> tb/priority_ceiling_task_scheduler_test.sv
// Testbench for the priority ceiling task scheduler: loads, runs, timing predictor.
module priority_ceiling_task_scheduler_test;

  // Run-length and pacing knobs.
  localparam int CYCLE_LIMIT  = 10000000;
  localparam int ITEM_TARGET  = 430;
  localparam int SETTLE       = 8;     // loads finish right away; the rest is margin

  // Receiver stall patterns, cycled through in turn.
  localparam int ST_NONE  = 0;
  localparam int ST_HALF  = 1;
  localparam int ST_RARE  = 2;
  localparam int ST_LONG  = 3;

  // Codes with no meaning to the block: ignored opcode, no-op instruction kind.
  localparam logic [1:0] OP_IGNORED = 2'd3;
  localparam logic [1:0] K_NOP      = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  pcts_pkg::in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  pcts_pkg::out_t out_data;
  logic cfg_we = 1'b0;
  logic cfg_index = pcts_pkg::REG_TASK_COUNT;
  logic [3:0] cfg_data = 4'd0;

  priority_ceiling_task_scheduler dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------------
  // Scheduler predictor: its own copy of program memory, ceilings and the
  // run-time state. Updated once per accepted input beat.
  // ---------------------------------------------------------------------
  bit [15:0] sch_start[pcts_pkg::MAX_TASKS];
  bit [7:0]  sch_prio[pcts_pkg::MAX_TASKS];
  bit [4:0]  sch_len[pcts_pkg::MAX_TASKS];
  bit [1:0]  sch_kind[pcts_pkg::MAX_TASKS*pcts_pkg::MAX_INSTRUCTIONS];
  bit [15:0] sch_val[pcts_pkg::MAX_TASKS*pcts_pkg::MAX_INSTRUCTIONS];
  int        sch_ptr[pcts_pkg::MAX_TASKS];
  bit [7:0]  sch_ceil[pcts_pkg::MAX_RESOURCES];
  int        sch_holder[pcts_pkg::MAX_RESOURCES];  // 0 free, else task+1
  bit [7:0]  sch_cur[pcts_pkg::MAX_TASKS];
  bit [31:0] sch_fin[pcts_pkg::MAX_TASKS];
  bit        sch_done[pcts_pkg::MAX_TASKS];
  bit [31:0] sch_now;
  int        sch_nfin;
  bit [3:0]  sch_task_cfg = 4'd1;
  bit [3:0]  sch_res_cfg = 4'd1;

  pcts_pkg::out_t expected_done[$];
  int   errors = 0;

  function automatic int clamp_count(bit [3:0] v, int hi);
    if (v == 0) return 1;
    if (int'(v) > hi) return hi;
    return int'(v);
  endfunction

  function automatic int prog_len(int t);
    return (int'(sch_len[t]) > pcts_pkg::MAX_INSTRUCTIONS) ? pcts_pkg::MAX_INSTRUCTIONS :
           int'(sch_len[t]);
  endfunction

  // Inheritance fixpoint, then highest unblocked ready task; returns task+1.
  function automatic int pick_task(int nt, int nr);
    int best, k, r, h;
    bit [7:0] bestp;
    bit changed, blocked;
    for (int i = 0; i < nt; i++) sch_cur[i] = sch_prio[i];
    do begin
      changed = 0;
      bestp = 0;
      best = 0;
      for (int i = 0; i < nt; i++) begin
        blocked = 0;
        if (sch_done[i] || sch_now < {16'd0, sch_start[i]} || sch_ptr[i] >= prog_len(i))
          continue;
        k = i*pcts_pkg::MAX_INSTRUCTIONS + sch_ptr[i];
        r = int'(sch_val[k]);
        if (sch_kind[k] == pcts_pkg::K_LOCK && r >= 1 && r <= nr) begin
          h = sch_holder[r-1];
          if (h != 0) begin
            blocked = 1;
            if (sch_cur[h-1] < sch_cur[i]) begin
              sch_cur[h-1] = sch_cur[i];
              changed = 1;
            end
          end
          for (int j = 0; j < nr; j++) begin
            h = sch_holder[j];
            if (h != 0 && h != i+1 && sch_ceil[j] >= sch_cur[i]) begin
              blocked = 1;
              if (sch_cur[h-1] < sch_cur[i]) begin
                sch_cur[h-1] = sch_cur[i];
                changed = 1;
              end
            end
          end
        end
        if (!blocked && sch_cur[i] > bestp) begin
          bestp = sch_cur[i];
          best = i + 1;
        end
      end
    end while (changed);
    return best;
  endfunction

  function automatic bit next_arrival(int nt, output bit [31:0] at);
    bit found;
    found = 0;
    at = 0;
    for (int i = 0; i < nt; i++)
      if (!sch_done[i] && {16'd0, sch_start[i]} > sch_now &&
          (!found || {16'd0, sch_start[i]} < at)) begin
        at = {16'd0, sch_start[i]};
        found = 1;
      end
    return found;
  endfunction

  function automatic void simulate_run(int nt, int nr);
    int b, t, k;
    bit [31:0] at, ticks, r;
    bit stop;
    sch_now = 0;
    sch_nfin = 0;
    stop = 0;
    for (int j = 0; j < pcts_pkg::MAX_RESOURCES; j++) sch_holder[j] = 0;
    for (int i = 0; i < pcts_pkg::MAX_TASKS; i++) begin
      sch_ptr[i] = 0;
      sch_fin[i] = 0;
      sch_done[i] = 0;
    end
    for (int i = 0; i < nt; i++)
      if (prog_len(i) == 0) begin
        sch_done[i] = 1;
        sch_nfin++;
      end
    while (sch_nfin < nt && !stop) begin
      b = pick_task(nt, nr);
      if (b == 0) begin
        if (next_arrival(nt, at)) begin
          sch_now = at;
          continue;
        end
        // Deadlock: whoever is left never finishes.
        for (int i = 0; i < nt; i++)
          if (!sch_done[i]) begin
            sch_fin[i] = pcts_pkg::TIME_MAX;
            sch_done[i] = 1;
            sch_nfin++;
          end
        stop = 1;
        continue;
      end
      t = b - 1;
      k = t*pcts_pkg::MAX_INSTRUCTIONS + sch_ptr[t];
      r = {16'd0, sch_val[k]};
      if (sch_kind[k] == pcts_pkg::K_COMPUTE && r > 0) begin
        ticks = r;
        if (next_arrival(nt, at) && at - sch_now < ticks) ticks = at - sch_now;
        sch_val[k] = 16'(r - ticks);
        sch_now = (pcts_pkg::TIME_MAX - sch_now < ticks) ? pcts_pkg::TIME_MAX : sch_now + ticks;
      end else begin
        if (r >= 1 && r <= nr) begin
          if (sch_kind[k] == pcts_pkg::K_LOCK) sch_holder[r-1] = b;
          else if (sch_kind[k] == pcts_pkg::K_UNLOCK) sch_holder[r-1] = 0;
        end
        sch_ptr[t]++;
        if (sch_ptr[t] >= prog_len(t)) begin
          sch_fin[t] = sch_now;
          sch_done[t] = 1;
          sch_nfin++;
        end
      end
    end
    for (int j = 0; j < pcts_pkg::MAX_RESOURCES; j++) sch_ceil[j] = 0;
  endfunction

  function automatic void apply_beat(pcts_pkg::in_t b);
    int nt, nr, k;
    pcts_pkg::out_t o;
    case (b.operation)
      pcts_pkg::OP_HDR: begin
        sch_start[b.task_index] = b.start_time;
        sch_prio[b.task_index] = b.base_priority;
        sch_len[b.task_index] = b.instr_count;
      end
      pcts_pkg::OP_INSTR: begin
        k = int'(b.task_index)*pcts_pkg::MAX_INSTRUCTIONS + int'(b.slot);
        sch_kind[k] = b.kind;
        sch_val[k] = b.value;
        // Ceiling tracks every lock loaded, whatever resource_count is.
        if (b.kind == pcts_pkg::K_LOCK && b.value >= 1 &&
            int'(b.value) <= pcts_pkg::MAX_RESOURCES &&
            sch_ceil[b.value-1] < sch_prio[b.task_index])
          sch_ceil[b.value-1] = sch_prio[b.task_index];
      end
      pcts_pkg::OP_RUN: begin
        nt = clamp_count(sch_task_cfg, pcts_pkg::MAX_TASKS);
        nr = clamp_count(sch_res_cfg, pcts_pkg::MAX_RESOURCES);
        simulate_run(nt, nr);
        for (int i = 0; i < nt; i++) begin
          o.done_task = i[2:0];
          o.done_time = sch_fin[i];
          o.last = (i + 1 == nt);
          expected_done.push_back(o);
        end
      end
      default: ;  // operation 3 does nothing
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Sender: bursts of beats from the pending queue with random gaps.
  // Some stretches run with no gaps at all.
  // ---------------------------------------------------------------------
  pcts_pkg::in_t pending[$];
  int  burst_left = 0;
  int  gap_left = 0;
  bit  took;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      took = in_valid && !in_stall;
      if (took) apply_beat(in_data);
      if (in_valid && !took) begin
        // stalled beat stays put
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending.size() > 0) begin
        in_data <= pending.pop_front();
        in_valid <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Receiver: stall pattern plus result checking against the oldest
  // expectation, field by field.
  // ---------------------------------------------------------------------
  int cycle = 0;
  pcts_pkg::out_t want;

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      if (!rst && out_valid && !out_stall) begin
        if (expected_done.size() == 0) begin
          $display("%0t: unexpected result beat task=%0d time=%0h last=%0b", $time,
                   out_data.done_task, out_data.done_time, out_data.last);
          errors++;
        end else begin
          want = expected_done.pop_front();
          if (out_data.done_task !== want.done_task) begin
            $display("%0t: done_task expected %0d actual %0d", $time,
                     want.done_task, out_data.done_task);
            errors++;
          end
          if (out_data.done_time !== want.done_time) begin
            $display("%0t: done_time of task %0d expected %0h actual %0h", $time,
                     want.done_task, want.done_time, out_data.done_time);
            errors++;
          end
          if (out_data.last !== want.last) begin
            $display("%0t: last of task %0d expected %0b actual %0b", $time,
                     want.done_task, want.last, out_data.last);
            errors++;
          end
        end
      end
      case ((cycle >> 7) % 4)
        ST_NONE: out_stall <= 1'b0;
        ST_HALF: out_stall <= 1'($urandom_range(0, 1));
        ST_RARE: out_stall <= ($urandom_range(0, 7) == 0);
        default: out_stall <= ((cycle % 23) < 15);
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus. The generator tracks what has been loaded so that no run
  // ever reads a header or an instruction slot that was never written.
  // ---------------------------------------------------------------------
  bit hdr_loaded[pcts_pkg::MAX_TASKS];
  bit slot_loaded[pcts_pkg::MAX_TASKS][pcts_pkg::MAX_INSTRUCTIONS];
  bit [4:0] loaded_len[pcts_pkg::MAX_TASKS];
  int items = 0;

  function automatic pcts_pkg::in_t noise_beat();
    pcts_pkg::in_t b;
    b = pcts_pkg::in_t'(56'({$urandom, $urandom}));
    return b;
  endfunction

  task automatic push_beat(pcts_pkg::in_t b);
    pending.push_back(b);
    items++;
  endtask

  task automatic load_header(int t, bit [15:0] st, bit [7:0] pr, bit [4:0] len);
    pcts_pkg::in_t b;
    b = noise_beat();
    b.operation = pcts_pkg::OP_HDR;
    b.task_index = 3'(t);
    b.start_time = st;
    b.base_priority = pr;
    b.instr_count = len;
    hdr_loaded[t] = 1;
    loaded_len[t] = len;
    push_beat(b);
  endtask

  task automatic load_instr(int t, int s, bit [1:0] kd, bit [15:0] v);
    pcts_pkg::in_t b;
    b = noise_beat();
    b.operation = pcts_pkg::OP_INSTR;
    b.task_index = 3'(t);
    b.slot = 4'(s);
    b.kind = kd;
    b.value = v;
    slot_loaded[t][s] = 1;
    push_beat(b);
  endtask

  task automatic push_op(bit [1:0] op);
    pcts_pkg::in_t b;
    b = noise_beat();
    b.operation = op;
    push_beat(b);
  endtask

  // Sender holds off until every result is in and the block is quiet.
  task automatic wait_quiet();
    while (pending.size() > 0 || in_valid || expected_done.size() > 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, bit [3:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    if (idx == pcts_pkg::REG_TASK_COUNT) sch_task_cfg = v;
    else sch_res_cfg = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic bit task_ready(int t);
    int n;
    if (!hdr_loaded[t]) return 0;
    n = (int'(loaded_len[t]) > pcts_pkg::MAX_INSTRUCTIONS) ? pcts_pkg::MAX_INSTRUCTIONS :
        int'(loaded_len[t]);
    for (int s = 0; s < n; s++) if (!slot_loaded[t][s]) return 0;
    return 1;
  endfunction

  // One random instruction: mostly sensible resources, sometimes bad ones.
  task automatic random_instr(int t, int s, int nr);
    int pick;
    bit [1:0] kd;
    bit [15:0] v;
    pick = $urandom_range(0, 19);
    if (pick < 8) begin
      kd = pcts_pkg::K_COMPUTE;
      v = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 12));
    end else begin
      kd = (pick < 14) ? pcts_pkg::K_LOCK : (pick < 19) ? pcts_pkg::K_UNLOCK : K_NOP;
      v = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(1, nr));
    end
    load_instr(t, s, kd, v);
  endtask

  task automatic random_scenario();
    int nt, nr, n;
    bit [15:0] st;
    bit [7:0] pr;
    bit [4:0] len;
    bit reuse;
    nt = clamp_count(sch_task_cfg, pcts_pkg::MAX_TASKS);
    nr = clamp_count(sch_res_cfg, pcts_pkg::MAX_RESOURCES);
    reuse = ($urandom_range(0, 4) == 0);
    for (int t = 0; t < nt; t++) if (!task_ready(t)) reuse = 0;
    if (!reuse) begin
      for (int t = 0; t < nt; t++) begin
        st = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 20));
        case ($urandom_range(0, 15))
          0:       pr = 8'd0;
          1, 2, 3: pr = 8'($urandom_range(1, 255));
          default: pr = 8'($urandom_range(1, 6));
        endcase
        case ($urandom_range(0, 19))
          0:       len = 5'd0;
          1:       len = 5'($urandom_range(16, 31));
          default: len = 5'($urandom_range(1, 5));
        endcase
        load_header(t, st, pr, len);
        n = (int'(len) > pcts_pkg::MAX_INSTRUCTIONS) ? pcts_pkg::MAX_INSTRUCTIONS : int'(len);
        for (int s = 0; s < n; s++) random_instr(t, s, nr);
      end
    end
    // A little noise: ignored opcode, and a stray instruction rewrite.
    if ($urandom_range(0, 5) == 0) push_op(OP_IGNORED);
    if ($urandom_range(0, 5) == 0 && hdr_loaded[0])
      random_instr(0, $urandom_range(0, pcts_pkg::MAX_INSTRUCTIONS-1), nr);
    push_op(pcts_pkg::OP_RUN);
  endtask

  initial begin
    bit [3:0] tc, rc;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed part, reset configuration of one task and one resource.
    // Latest start and top priority, lock/long compute/unlock.
    load_header(0, 16'hFFFF, 8'hFF, 5'd3);
    load_instr(0, 0, pcts_pkg::K_LOCK, 16'd1);
    load_instr(0, 1, pcts_pkg::K_COMPUTE, 16'hFFFF);
    load_instr(0, 2, pcts_pkg::K_UNLOCK, 16'd1);
    push_op(pcts_pkg::OP_RUN);
    push_op(pcts_pkg::OP_RUN);             // compute already used up
    push_op(OP_IGNORED);                   // ignored opcode
    load_header(0, 16'd0, 8'd1, 5'd0);     // empty program
    push_op(pcts_pkg::OP_RUN);
    load_header(0, 16'd5, 8'd0, 5'd1);     // priority zero: deadlock
    load_instr(0, 0, pcts_pkg::K_COMPUTE, 16'd5);
    push_op(pcts_pkg::OP_RUN);
    load_header(0, 16'd2, 8'd9, 5'd4);     // bad resources and no-op kind
    load_instr(0, 0, pcts_pkg::K_LOCK, 16'd0);
    load_instr(0, 1, pcts_pkg::K_LOCK, 16'd9);
    load_instr(0, 2, K_NOP, 16'hFFFF);
    load_instr(0, 3, pcts_pkg::K_UNLOCK, 16'd1);  // unlock with nothing held
    push_op(pcts_pkg::OP_RUN);
    wait_quiet();

    // Random phases, each under its own register setting; the first ones use eight tasks and two resources.
    while (items < ITEM_TARGET) begin
      case ($urandom_range(0, 5))
        0: begin tc = 4'd8;  rc = 4'd8;  end
        1: begin tc = 4'd1;  rc = 4'd1;  end
        2: begin tc = 4'd15; rc = 4'd0;  end
        3: begin tc = 4'd0;  rc = 4'd15; end
        default: begin tc = 4'($urandom_range(1, 8)); rc = 4'($urandom_range(1, 8)); end
      endcase
      if (items < 40) begin
        tc = 4'd8;
        rc = 4'd2;
      end
      write_reg(pcts_pkg::REG_TASK_COUNT, tc);
      write_reg(pcts_pkg::REG_RESOURCE_COUNT, rc);
      repeat ($urandom_range(2, 5)) if (items < ITEM_TARGET) random_scenario();
      wait_quiet();
    end

    wait_quiet();
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+src
src/pcts_pkg.sv
src/pcts_datapath.sv
src/pcts_controller.sv
src/priority_ceiling_task_scheduler.sv
tb/priority_ceiling_task_scheduler_test.sv
